### src/h2rgb_pkg.sv
// Shared constants for the HSL to RGB converter pipeline.
// Standalone package with no dependencies.
package h2rgb_pkg;

  localparam int unsigned SEXT_W = 3;
  localparam int unsigned BYTE_W = 8;

  // Hue sextant codes; sextant six folds into sextant zero.
  localparam logic [SEXT_W-1:0] SEXT_0 = 3'd0;
  localparam logic [SEXT_W-1:0] SEXT_1 = 3'd1;
  localparam logic [SEXT_W-1:0] SEXT_2 = 3'd2;
  localparam logic [SEXT_W-1:0] SEXT_3 = 3'd3;
  localparam logic [SEXT_W-1:0] SEXT_4 = 3'd4;
  localparam logic [SEXT_W-1:0] SEXT_5 = 3'd5;
  localparam logic [SEXT_W-1:0] SEXT_6 = 3'd6;

  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;
  localparam logic [BYTE_W-1:0] BYTE_MIN = 8'd0;

endpackage

### src/hsl_to_rgb_converter_core.sv
// Top level of the HSL to RGB converter: five-stage pipeline with valid/stall control.
// Depends on h2rgb_pkg, h2rgb_prep, h2rgb_span, h2rgb_blend and h2rgb_quant.
//
// Usage:
// The input channel carries hue, saturation and lightness as unsigned fractions with
// FRAC_BITS fraction bits; values above 1.0 are clamped. A transaction completes on a
// rising edge where in_valid_i is high and in_stall_o is low. The output channel carries
// one red, green and blue byte per input transaction and completes where out_valid_o is
// high and out_stall_i is low.
// An accepted transaction passes through the prep, span, blend and quant registers in
// that order before out_valid_o rises. Throughput is one transaction per cycle while the
// receiver does not stall: each of the five register stages advances whenever it is empty
// or the stage after it advances, so bubbles are squeezed out while the receiver stalls.
// in_stall_o rises only once all five stages hold data and the receiver stalls.
// Reset clears all stage valid bits, so the block accepts input as soon as reset is released.
// There are no configuration registers and no state between transactions.
module hsl_to_rgb_converter_core import h2rgb_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FRAC_BITS:0]   hue_i,
  input  logic [FRAC_BITS:0]   saturation_i,
  input  logic [FRAC_BITS:0]   lightness_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [BYTE_W-1:0]    red_out_o,
  output logic [BYTE_W-1:0]    green_out_o,
  output logic [BYTE_W-1:0]    blue_out_o
);

  localparam int unsigned NumStages = 5;

  logic [NumStages-1:0] valid_q, valid_d, adv;

  logic [FRAC_BITS:0]   p_light, p_sat, p_ls;
  logic [SEXT_W-1:0]    p_sext;
  logic [FRAC_BITS-1:0] p_fract;

  logic [FRAC_BITS:0]   s_light;
  logic [FRAC_BITS+1:0] s_v, s_m, s_diff;
  logic                 s_gray;
  logic [SEXT_W-1:0]    s_sext;
  logic [FRAC_BITS-1:0] s_fract;

  logic [FRAC_BITS+1:0] b_red, b_green, b_blue;

  // A stage advances when it is empty or its successor advances.
  always_comb begin
    adv[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    valid_d[0] = in_valid_i;
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (adv[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[NumStages-1];

  h2rgb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk_i        (clk_i),
    .en_i         (adv[0]),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .lightness_i  (lightness_i),
    .light_o      (p_light),
    .sat_o        (p_sat),
    .ls_o         (p_ls),
    .sext_o       (p_sext),
    .fract_o      (p_fract)
  );

  h2rgb_span #(.FRAC_BITS(FRAC_BITS)) u_span (
    .clk_i   (clk_i),
    .en_i    (adv[1]),
    .light_i (p_light),
    .sat_i   (p_sat),
    .ls_i    (p_ls),
    .sext_i  (p_sext),
    .fract_i (p_fract),
    .light_o (s_light),
    .v_o     (s_v),
    .m_o     (s_m),
    .diff_o  (s_diff),
    .gray_o  (s_gray),
    .sext_o  (s_sext),
    .fract_o (s_fract)
  );

  h2rgb_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk_i   (clk_i),
    .en_i    (adv[3:2]),
    .light_i (s_light),
    .v_i     (s_v),
    .m_i     (s_m),
    .diff_i  (s_diff),
    .gray_i  (s_gray),
    .sext_i  (s_sext),
    .fract_i (s_fract),
    .red_o   (b_red),
    .green_o (b_green),
    .blue_o  (b_blue)
  );

  h2rgb_quant #(.FRAC_BITS(FRAC_BITS)) u_quant (
    .clk_i   (clk_i),
    .en_i    (adv[4]),
    .red_i   (b_red),
    .green_i (b_green),
    .blue_i  (b_blue),
    .red_o   (red_out_o),
    .green_o (green_out_o),
    .blue_o  (blue_out_o)
  );

  // An accepted transaction always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted transaction missing from first stage");

  // Backpressure reaches the input only when every stage is occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q && out_stall_i))
    else $error("input stalled while pipeline has a bubble");

  // The stage before the output stage hands valid data on whenever the output stage advances.
  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NumStages-2] && adv[NumStages-1]) |=> valid_q[NumStages-1])
    else $error("transaction lost before output stage");

endmodule

### src/h2rgb_prep.sv
// First pipeline stage: input clamping, lightness times saturation, hue sextant split.
// Depends on h2rgb_pkg.
module h2rgb_prep import h2rgb_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS:0]   hue_i,
  input  logic [FRAC_BITS:0]   saturation_i,
  input  logic [FRAC_BITS:0]   lightness_i,
  output logic [FRAC_BITS:0]   light_o,
  output logic [FRAC_BITS:0]   sat_o,
  output logic [FRAC_BITS:0]   ls_o,
  output logic [SEXT_W-1:0]    sext_o,
  output logic [FRAC_BITS-1:0] fract_o
);

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0]     hue_c, sat_c, light_c, hue_inv;
  logic [2*FRAC_BITS+1:0] ls_prod;
  logic [FRAC_BITS+2:0]   hp;

  logic [FRAC_BITS:0]     light_q, sat_q, ls_q;
  logic [SEXT_W-1:0]      sext_q;
  logic [FRAC_BITS-1:0]   fract_q;

  always_comb begin
    hue_c   = (hue_i > ONE) ? ONE : hue_i;
    sat_c   = (saturation_i > ONE) ? ONE : saturation_i;
    light_c = (lightness_i > ONE) ? ONE : lightness_i;
    ls_prod = light_c * sat_c;
    hue_inv = ONE - hue_c;
    // Times six as a sum of two shifts.
    hp      = {hue_inv, 2'b00} + {1'b0, hue_inv, 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      light_q <= light_c;
      sat_q   <= sat_c;
      ls_q    <= ls_prod[2*FRAC_BITS:FRAC_BITS];
      sext_q  <= hp[FRAC_BITS+2:FRAC_BITS];
      fract_q <= hp[FRAC_BITS-1:0];
    end
  end

  assign light_o = light_q;
  assign sat_o   = sat_q;
  assign ls_o    = ls_q;
  assign sext_o  = sext_q;
  assign fract_o = fract_q;

endmodule

### src/h2rgb_span.sv
// Second pipeline stage: computes v, m and their difference from lightness and saturation.
// Depends on h2rgb_pkg.
module h2rgb_span import h2rgb_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS:0]   light_i,
  input  logic [FRAC_BITS:0]   sat_i,
  input  logic [FRAC_BITS:0]   ls_i,
  input  logic [SEXT_W-1:0]    sext_i,
  input  logic [FRAC_BITS-1:0] fract_i,
  output logic [FRAC_BITS:0]   light_o,
  output logic [FRAC_BITS+1:0] v_o,
  output logic [FRAC_BITS+1:0] m_o,
  output logic [FRAC_BITS+1:0] diff_o,
  output logic                 gray_o,
  output logic [SEXT_W-1:0]    sext_o,
  output logic [FRAC_BITS-1:0] fract_o
);

  localparam logic [FRAC_BITS:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

  logic [FRAC_BITS+1:0] v_d, m_d, diff_d;
  logic [FRAC_BITS+2:0] m_raw, diff_raw;

  logic [FRAC_BITS:0]   light_q;
  logic [FRAC_BITS+1:0] v_q, m_q, diff_q;
  logic                 gray_q;
  logic [SEXT_W-1:0]    sext_q;
  logic [FRAC_BITS-1:0] fract_q;

  always_comb begin
    // For the lower half, L*(1+S) splits exactly into L plus the truncated L*S.
    if (light_i <= HALF) begin
      v_d = {1'b0, light_i} + {1'b0, ls_i};
    end else begin
      v_d = {1'b0, light_i} + {1'b0, sat_i} - {1'b0, ls_i};
    end
    m_raw    = {1'b0, light_i, 1'b0} - {1'b0, v_d};
    m_d      = m_raw[FRAC_BITS+2] ? '0 : m_raw[FRAC_BITS+1:0];
    diff_raw = {1'b0, v_d} - {1'b0, m_d};
    diff_d   = diff_raw[FRAC_BITS+2] ? '0 : diff_raw[FRAC_BITS+1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      light_q <= light_i;
      v_q     <= v_d;
      m_q     <= m_d;
      diff_q  <= diff_d;
      gray_q  <= (v_d == '0);
      sext_q  <= sext_i;
      fract_q <= fract_i;
    end
  end

  assign light_o = light_q;
  assign v_o     = v_q;
  assign m_o     = m_q;
  assign diff_o  = diff_q;
  assign gray_o  = gray_q;
  assign sext_o  = sext_q;
  assign fract_o = fract_q;

endmodule

### src/h2rgb_blend.sv
// Third and fourth pipeline stages: hue fraction product, then per-sextant channel select.
// Depends on h2rgb_pkg.
module h2rgb_blend import h2rgb_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  logic [FRAC_BITS:0]   light_i,
  input  logic [FRAC_BITS+1:0] v_i,
  input  logic [FRAC_BITS+1:0] m_i,
  input  logic [FRAC_BITS+1:0] diff_i,
  input  logic                 gray_i,
  input  logic [SEXT_W-1:0]    sext_i,
  input  logic [FRAC_BITS-1:0] fract_i,
  output logic [FRAC_BITS+1:0] red_o,
  output logic [FRAC_BITS+1:0] green_o,
  output logic [FRAC_BITS+1:0] blue_o
);

  logic [2*FRAC_BITS+1:0] vsf_prod;

  logic [FRAC_BITS:0]     light_q;
  logic [FRAC_BITS+1:0]   v_q, m_q, vsf_q;
  logic                   gray_q;
  logic [SEXT_W-1:0]      sext_q;

  logic [FRAC_BITS+1:0]   mid1, mid2, red_d, green_d, blue_d, gray_val;
  logic [FRAC_BITS+1:0]   red_q, green_q, blue_q;

  assign vsf_prod = diff_i * fract_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      light_q <= light_i;
      v_q     <= v_i;
      m_q     <= m_i;
      vsf_q   <= vsf_prod[2*FRAC_BITS+1:FRAC_BITS];
      gray_q  <= gray_i;
      sext_q  <= sext_i;
    end
  end

  always_comb begin
    mid1     = m_q + vsf_q;
    mid2     = v_q - vsf_q;
    gray_val = {1'b0, light_q};
    case (sext_q)
      SEXT_1: begin
        red_d = mid2; green_d = v_q;  blue_d = m_q;
      end
      SEXT_2: begin
        red_d = m_q;  green_d = v_q;  blue_d = mid1;
      end
      SEXT_3: begin
        red_d = m_q;  green_d = mid2; blue_d = v_q;
      end
      SEXT_4: begin
        red_d = mid1; green_d = m_q;  blue_d = v_q;
      end
      SEXT_5: begin
        red_d = v_q;  green_d = m_q;  blue_d = mid2;
      end
      default: begin
        red_d = v_q;  green_d = mid1; blue_d = m_q;
      end
    endcase
    if (gray_q) begin
      red_d   = gray_val;
      green_d = gray_val;
      blue_d  = gray_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

### src/h2rgb_quant.sv
// Last pipeline stage: scales each channel fraction to a clamped byte.
// Depends on h2rgb_pkg.
module h2rgb_quant import h2rgb_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS+1:0] red_i,
  input  logic [FRAC_BITS+1:0] green_i,
  input  logic [FRAC_BITS+1:0] blue_i,
  output logic [BYTE_W-1:0]    red_o,
  output logic [BYTE_W-1:0]    green_o,
  output logic [BYTE_W-1:0]    blue_o
);

  function automatic logic [BYTE_W-1:0] to_byte(input logic [FRAC_BITS+1:0] x);
    logic [FRAC_BITS-1:0]        xl;
    logic [FRAC_BITS+BYTE_W-1:0] scaled;
    xl     = x[FRAC_BITS-1:0];
    // Times 255 as a shift and a subtract.
    scaled = {xl, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, xl};
    if (x[FRAC_BITS+1:FRAC_BITS] != 2'b00) begin
      to_byte = BYTE_MAX;
    end else if (x == '0) begin
      to_byte = BYTE_MIN;
    end else begin
      to_byte = scaled[FRAC_BITS+BYTE_W-1:FRAC_BITS];
    end
  endfunction

  logic [BYTE_W-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= to_byte(red_i);
      green_q <= to_byte(green_i);
      blue_q  <= to_byte(blue_i);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule
